### rtl/core/umrf_pkg.sv
// shared types and constants for the ultrasonic median range filter
// no dependencies; compiled first
`default_nettype none

package umrf_pkg;

   localparam int DIST_W    = 22;
   localparam int ECHO_W    = 16;
   localparam int LIMIT_W   = 21;
   localparam int PROD_W    = 21;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 21;

   typedef logic signed [DIST_W-1:0] distance_type;

   localparam distance_type MISS_DISTANCE = -22'sd1000;
   localparam logic [PROD_W-1:0] SCALE_PER_US = 21'd17;

   localparam logic [ECHO_W-1:0]  TIMEOUT_RESET = 16'd30000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 21'd100000;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_US     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_LIMIT = 1'b1;

   // control from the sequencer to the median unit
   typedef struct packed {
      logic load_en;
      logic start;
   } sel_ctrl_type;

   // status back from the median unit
   typedef struct packed {
      logic         busy;
      logic         done;
      distance_type median;
   } sel_status_type;

endpackage

`default_nettype wire

### rtl/core/umrf_if.sv
// valid/ready channel interfaces for echo requests and median responses
// depends on umrf_pkg
`default_nettype none

interface umrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  sensor_index;
   logic [15:0] echo_width;

   modport source (output valid, output sensor_index, output echo_width, input ready);
   modport sink   (input valid, input sensor_index, input echo_width, output ready);
endinterface

interface umrf_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             sensor_id;
   umrf_pkg::distance_type median_distance;
   logic                   obstacle_any;

   modport source (output valid, output sensor_id, output median_distance,
                   output obstacle_any, input ready);
   modport sink   (input valid, input sensor_id, input median_distance,
                   input obstacle_any, output ready);
endinterface

`default_nettype wire

### rtl/core/umrf_sample_ram.sv
// sample window storage: one write port, one read port, registered read data
// depends on umrf_pkg
`default_nettype none

module umrf_sample_ram #(
   parameter int DEPTH  = 15,
   parameter int ADDR_W = 4
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [ADDR_W-1:0]             wr_addr,
   input  wire umrf_pkg::distance_type  wr_data,
   input  wire                          rd_en,
   input  wire [ADDR_W-1:0]             rd_addr,
   output umrf_pkg::distance_type       rd_data
);

   umrf_pkg::distance_type mem_ff [DEPTH];
   umrf_pkg::distance_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/umrf_median_select.sv
// rank-based median selection over a small window buffer, one candidate per cycle
// depends on umrf_pkg
`default_nettype none

module umrf_median_select #(
   parameter int WINDOW_SIZE = 5,
   parameter int CNT_W       = 3
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire umrf_pkg::sel_ctrl_type ctrl,
   input  wire [CNT_W-1:0]           load_idx,
   input  wire umrf_pkg::distance_type load_data,
   output umrf_pkg::sel_status_type  status
);

   localparam int RANK_W = $clog2(WINDOW_SIZE + 1);
   localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_SIZE / 2);
   localparam logic [CNT_W-1:0]  LAST_CAND = CNT_W'(WINDOW_SIZE - 1);

   umrf_pkg::distance_type buf_ff [WINDOW_SIZE];
   umrf_pkg::distance_type median_ff;
   logic [CNT_W-1:0]       cand_ff;
   logic                   active_ff;
   logic                   done_ff;

   umrf_pkg::distance_type cand_val;
   logic [RANK_W-1:0]      less_cnt;
   logic [RANK_W-1:0]      leq_cnt;
   logic                   is_median;

   // count of entries strictly below and at-or-below the candidate
   always_comb begin
      cand_val = buf_ff[cand_ff];
      less_cnt = '0;
      leq_cnt  = '0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
         if (buf_ff[j] < cand_val) begin
            less_cnt = less_cnt + RANK_W'(1);
         end
         if (buf_ff[j] <= cand_val) begin
            leq_cnt = leq_cnt + RANK_W'(1);
         end
      end
      is_median = (less_cnt <= MID_RANK) && (leq_cnt > MID_RANK);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_en) begin
         buf_ff[load_idx] <= load_data;
      end
      if (active_ff && is_median) begin
         median_ff <= cand_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cand_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            active_ff <= 1'b1;
            cand_ff   <= '0;
         end else if (active_ff) begin
            if (cand_ff == LAST_CAND) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end else begin
               cand_ff <= cand_ff + CNT_W'(1);
            end
         end
      end
   end

   assign status.busy   = active_ff;
   assign status.done   = done_ff;
   assign status.median = median_ff;

endmodule

`default_nettype wire

### rtl/core/ultrasonic_median_range_filter.sv
// sequence: an item that does not complete a window is stored and the block stays idle;
//   an item that completes one raises response valid after the window is reduced
//   (WINDOW_SIZE-1 sample ram reads, then one rank test per window entry)
// throughput: one item per cycle while windows fill; no request is taken until a closed window's response is registered
// reset: synchronous active high; counts cleared, latest medians set to no echo,
//   registers to their defaults; sample ram needs no clearing
`default_nettype none

module ultrasonic_median_range_filter #(
   parameter int SENSOR_COUNT = 3,
   parameter int WINDOW_SIZE  = 5
) (
   input  wire                                  clock,
   input  wire                                  reset,
   umrf_req_if.sink                             req_chan,
   umrf_rsp_if.source                           rsp_chan,
   input  wire                                  csr_write_en,
   input  wire [umrf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [umrf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DEPTH  = SENSOR_COUNT * WINDOW_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_SIZE);
   localparam int SENS_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int SX_W   = SENS_W + 2;

   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(WINDOW_SIZE - 1);
   localparam logic [CNT_W-1:0] LAST_READ = CNT_W'(WINDOW_SIZE - 2);

   // one-hot sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SELECT = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [umrf_pkg::ECHO_W-1:0]  timeout_ff;
   logic [umrf_pkg::LIMIT_W-1:0] limit_ff;

   // per-sensor control state
   logic [CNT_W-1:0]       count_ff [SENSOR_COUNT];
   logic [CNT_W-1:0]       count_in [SENSOR_COUNT];
   umrf_pkg::distance_type last_med_ff [SENSOR_COUNT];
   umrf_pkg::distance_type last_med_in [SENSOR_COUNT];

   // window being reduced
   logic [SENS_W-1:0] sensor_ff, sensor_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              start_ff, start_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SENS_W-1:0]      rsp_sensor_ff;
   umrf_pkg::distance_type rsp_median_ff;
   logic                   rsp_flag_ff;

   // request decode
   logic                          accept;
   logic [SX_W-1:0]               req_sensor_wide;
   logic [SENS_W-1:0]             req_sensor;
   logic                          in_range;
   logic [CNT_W-1:0]              req_count;
   logic [umrf_pkg::PROD_W-1:0]   scaled;
   logic                          is_miss;
   umrf_pkg::distance_type        sample_dist;

   // ram ports
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   umrf_pkg::distance_type rd_data;

   // median unit
   umrf_pkg::sel_ctrl_type   sel_ctrl;
   umrf_pkg::sel_status_type sel_status;
   logic [CNT_W-1:0]         load_idx;
   umrf_pkg::distance_type   load_data;

   logic             finish_fire;
   logic             flag_next;
   logic [SX_W-1:0]  rsp_sensor_wide;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   assign req_sensor_wide = SX_W'(req_chan.sensor_index);
   assign req_sensor      = req_sensor_wide[SENS_W-1:0];
   assign in_range        = req_sensor_wide < SX_W'(SENSOR_COUNT);
   assign req_count       = count_ff[req_sensor];

   // distance in 0.001 cm: width * 17, or the miss code
   assign scaled  = umrf_pkg::PROD_W'(req_chan.echo_width) * umrf_pkg::SCALE_PER_US;
   assign is_miss = (req_chan.echo_width == '0) || (req_chan.echo_width > timeout_ff);
   assign sample_dist = is_miss ? umrf_pkg::MISS_DISTANCE
                                : umrf_pkg::distance_type'({1'b0, scaled});

   // a filling sample goes to ram; the closing sample bypasses it straight into
   // the median buffer, so ram writes and reads never touch the same entry at once
   assign wr_en   = accept && in_range && (req_count != LAST_SLOT);
   assign wr_addr = ADDR_W'(req_sensor) * ADDR_W'(WINDOW_SIZE) + ADDR_W'(req_count);

   assign rd_en   = (state_ff == ST_LOAD);
   assign rd_addr = ADDR_W'(sensor_ff) * ADDR_W'(WINDOW_SIZE) + ADDR_W'(rd_idx_ff);

   // buffer load: closing sample on acceptance, ram entries in the cycle after their read
   always_comb begin
      sel_ctrl.start = start_ff;
      if (accept && in_range && (req_count == LAST_SLOT)) begin
         sel_ctrl.load_en = 1'b1;
         load_idx         = LAST_SLOT;
         load_data        = sample_dist;
      end else begin
         sel_ctrl.load_en = rd_pend_ff;
         load_idx         = pend_idx_ff;
         load_data        = rd_data;
      end
   end

   assign finish_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // obstacle flag over all latest medians, this sensor's one already replaced
   always_comb begin
      umrf_pkg::distance_type m;
      flag_next = 1'b0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
         m = (SENS_W'(s) == sensor_ff) ? sel_status.median : last_med_ff[s];
         if ((m > 0) && (m < umrf_pkg::distance_type'({1'b0, limit_ff}))) begin
            flag_next = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      sensor_in   = sensor_ff;
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = 1'b0;
      pend_idx_in = rd_idx_ff;
      start_in    = 1'b0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
         count_in[s]    = count_ff[s];
         last_med_in[s] = last_med_ff[s];
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               if (req_count == LAST_SLOT) begin
                  sensor_in = req_sensor;
                  rd_idx_in = '0;
                  state_in  = ST_LOAD;
               end else begin
                  count_in[req_sensor] = req_count + CNT_W'(1);
               end
            end
         end
         ST_LOAD: begin
            // read issued this cycle lands in the buffer next cycle
            rd_pend_in = 1'b1;
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
            if (rd_idx_ff == LAST_READ) begin
               start_in = 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (sel_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold here while the previous response is still unclaimed
            if (finish_fire) begin
               count_in[sensor_ff]    = '0;
               last_med_in[sensor_ff] = sel_status.median;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = finish_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= umrf_pkg::TIMEOUT_RESET;
         limit_ff     <= umrf_pkg::LIMIT_RESET;
         for (int s = 0; s < SENSOR_COUNT; s++) begin
            count_ff[s]    <= '0;
            last_med_ff[s] <= umrf_pkg::MISS_DISTANCE;
         end
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < SENSOR_COUNT; s++) begin
            count_ff[s]    <= count_in[s];
            last_med_ff[s] <= last_med_in[s];
         end
         // register writes, unused indexes fall through
         if (csr_write_en) begin
            case (csr_index)
               umrf_pkg::CSR_TIMEOUT_US: begin
                  timeout_ff <= csr_wdata[umrf_pkg::ECHO_W-1:0];
               end
               umrf_pkg::CSR_OBSTACLE_LIMIT: begin
                  limit_ff <= csr_wdata[umrf_pkg::LIMIT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sensor_ff   <= sensor_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      if (finish_fire) begin
         rsp_sensor_ff <= sensor_ff;
         rsp_median_ff <= sel_status.median;
         rsp_flag_ff   <= flag_next;
      end
   end

   assign rsp_sensor_wide          = SX_W'(rsp_sensor_ff);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sensor_id       = rsp_sensor_wide[1:0];
   assign rsp_chan.median_distance = rsp_median_ff;
   assign rsp_chan.obstacle_any    = rsp_flag_ff;

   umrf_sample_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (sample_dist),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   umrf_median_select #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .CNT_W       (CNT_W)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sel_ctrl),
      .load_idx  (load_idx),
      .load_data (load_data),
      .status    (sel_status)
   );

   // ram is written only while collecting samples
   a_write_in_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("sample ram written outside idle");

   // read data only arrives while the window is being loaded or just after
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ((state_ff == ST_LOAD) || (state_ff == ST_SELECT)))
      else $error("stray sample ram read data");

   // median unit reports completion only to a waiting sequencer
   a_done_in_select: assert property (@(posedge clock) disable iff (reset)
      sel_status.done |-> (state_ff == ST_SELECT))
      else $error("median done outside select");

   // a finished window always shows a response and an emptied count
   a_finish_response: assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> (rsp_valid_ff && (count_ff[$past(sensor_ff)] == '0)))
      else $error("finished window without response");

endmodule

`default_nettype wire
